### rtl/core/nbgv_pkg.sv
// shared types, constants and helpers for the n-body verlet step unit
// no dependencies
`default_nettype none
package nbgv_pkg;

    localparam logic [1:0] CFG_GRAV  = 2'd0;
    localparam logic [1:0] CFG_SOFT  = 2'd1;
    localparam logic [1:0] CFG_SUBST = 2'd2;

    localparam logic [30:0] GRAV_RESET  = 31'd65536;
    localparam logic [6:0]  SUBST_RESET = 7'd10;

    // squared distance threshold for pairs closer than 0.001, in q32.32
    localparam logic [63:0] DIST_MIN_SQ = 64'd4295;

    typedef struct packed {
        logic        go;
        logic [63:0] num_hi;
        logic [63:0] num_lo;
        logic [63:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } t_div_rsp;

    typedef struct packed {
        logic        go;
        logic [63:0] val;
    } t_sqrt_req;

    typedef struct packed {
        logic        done;
        logic [31:0] root;
    } t_sqrt_rsp;

    function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
        logic signed [31:0] r;
        if (v > 49'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < 49'sh1_FFFF_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? 32'(-v) : 32'(v);
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/core/nbgv_mul.sv
// shared 32x32 unsigned multiplier with registered product
// no dependencies
`default_nettype none
module nbgv_mul (
    input  wire logic        i_clk,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [63:0] o_prod
);
    logic [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_prod = r_prod;
endmodule
`default_nettype wire

### rtl/core/nbgv_div.sv
// restoring divider, 128 by 64 bit, one quotient bit a cycle, saturating
// uses nbgv_pkg
`default_nettype none
module nbgv_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire nbgv_pkg::t_div_req i_req,
    output nbgv_pkg::t_div_rsp     o_rsp
);
    logic [63:0] r_rem;
    logic [63:0] r_lo;
    logic [63:0] r_den;
    logic [63:0] r_q;
    logic [5:0]  r_cnt;
    logic        r_run;
    logic        r_done;
    logic [64:0] w_sh;
    logic        w_ge;

    assign w_sh = {r_rem, r_lo[63]};
    assign w_ge = w_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else if (i_req.go) begin
            r_den <= i_req.den;
            if (i_req.num_hi >= i_req.den) begin
                // quotient does not fit
                r_q    <= '1;
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_rem  <= i_req.num_hi;
                r_lo   <= i_req.num_lo;
                r_cnt  <= 6'd63;
                r_run  <= 1'b1;
                r_done <= 1'b0;
            end
        end else if (r_run) begin
            if (w_ge) begin
                r_rem <= 64'(w_sh - {1'b0, r_den});
                r_q   <= {r_q[62:0], 1'b1};
            end else begin
                r_rem <= w_sh[63:0];
                r_q   <= {r_q[62:0], 1'b0};
            end
            r_lo <= {r_lo[62:0], 1'b0};
            if (r_cnt == 6'd0) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;
endmodule
`default_nettype wire

### rtl/core/nbgv_sqrt.sv
// floor square root of a 64-bit value, two radicand bits a cycle
// uses nbgv_pkg
`default_nettype none
module nbgv_sqrt (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire nbgv_pkg::t_sqrt_req i_req,
    output nbgv_pkg::t_sqrt_rsp     o_rsp
);
    logic [63:0] r_v;
    logic [63:0] r_r;
    logic [63:0] r_bit;
    logic        r_run;
    logic        r_done;
    logic [63:0] w_tst;

    assign w_tst = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else if (i_req.go) begin
            r_v    <= i_req.val;
            r_r    <= 64'd0;
            r_bit  <= 64'h4000_0000_0000_0000;
            r_run  <= 1'b1;
            r_done <= 1'b0;
        end else if (r_run) begin
            if (r_v >= w_tst) begin
                r_v <= r_v - w_tst;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
            if (r_bit[0]) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_r[31:0];
endmodule
`default_nettype wire

### rtl/core/nbody_gravity_verlet_step_unit.sv
// n-body velocity-verlet step unit, q16.16, softened gravity
// uses nbgv_pkg, nbgv_mul, nbgv_div, nbgv_sqrt
// a load gives no result. in an advance, each pair that is not too close
// needs two ratio divisions and four pull divisions on the shared divider
// in every force pass. busy stays high during the advance, then N results
// follow on consecutive cycles. the receiver cannot stall. synchronous
// active-low reset clears control state, bodies and configuration
`default_nettype none
module nbody_gravity_verlet_step_unit #(
    parameter int NUM_BODIES = 3
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // command side
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_kind,
    input  wire logic        [1:0]  i_body_index,
    input  wire logic signed [31:0] i_in_pos_x,
    input  wire logic signed [31:0] i_in_pos_y,
    input  wire logic signed [31:0] i_in_vel_x,
    input  wire logic signed [31:0] i_in_vel_y,
    input  wire logic        [30:0] i_in_mass,
    input  wire logic        [30:0] i_step_dt,
    // configuration writes
    input  wire logic               i_cfg_we,
    input  wire logic        [1:0]  i_cfg_idx,
    input  wire logic        [30:0] i_cfg_data,
    // results
    output logic                    o_valid,
    output logic             [1:0]  o_out_index,
    output logic signed      [31:0] o_out_pos_x,
    output logic signed      [31:0] o_out_pos_y,
    output logic signed      [31:0] o_out_vel_x,
    output logic signed      [31:0] o_out_vel_y,
    output logic                    o_last
);
    localparam int IW = $clog2(NUM_BODIES);
    localparam logic [IW-1:0] LAST_B = IW'(NUM_BODIES - 1);
    localparam logic [IW-1:0] PEN_B  = IW'(NUM_BODIES - 2);

    typedef enum logic [4:0] {
        S_IDLE, S_G_RDI, S_G_RDJ, S_G_DIF, S_G_M0, S_G_M1, S_G_M2, S_G_M3,
        S_G_M4, S_G_M5, S_G_WD1, S_G_WD2, S_G_P0, S_G_P1, S_G_P2, S_G_PW,
        S_K_MUL, S_K_ADD, S_D_MUL, S_D_ADD, S_EMIT
    } t_state;

    t_state r_state;

    // body store
    logic signed [31:0] r_px  [NUM_BODIES];
    logic signed [31:0] r_py  [NUM_BODIES];
    logic signed [31:0] r_vx  [NUM_BODIES];
    logic signed [31:0] r_vy  [NUM_BODIES];
    logic        [30:0] r_m   [NUM_BODIES];
    logic signed [31:0] r_acx [NUM_BODIES];
    logic signed [31:0] r_acy [NUM_BODIES];

    // configuration
    logic [30:0] r_grav;
    logic [30:0] r_soft;
    logic [6:0]  r_subst;

    // sequencer working registers
    logic [30:0]        r_dt;
    logic [6:0]         r_cnt;
    logic               r_phase;
    logic [IW-1:0]      r_i;
    logic [IW-1:0]      r_j;
    logic [IW-1:0]      r_b;
    logic               r_ax;
    logic [1:0]         r_k;
    logic signed [31:0] r_pix, r_piy, r_pjx, r_pjy;
    logic [30:0]        r_mi, r_mj;
    logic signed [31:0] r_dx, r_dy;
    logic [63:0]        r_sum, r_den, r_gmi, r_ratj, r_rati, r_p0;
    logic [31:0]        r_dist;

    // result registers
    logic               r_valid;
    logic [1:0]         r_oidx;
    logic signed [31:0] r_opx, r_opy, r_ovx, r_ovy;
    logic               r_olast;

    // shared units
    logic [31:0]         w_ma, w_mb;
    logic [63:0]         w_prod;
    nbgv_pkg::t_div_req  w_dreq;
    nbgv_pkg::t_div_rsp  w_drsp;
    nbgv_pkg::t_sqrt_req w_sreq;
    nbgv_pkg::t_sqrt_rsp w_srsp;

    nbgv_mul u_mul (.i_clk(i_clk), .i_a(w_ma), .i_b(w_mb), .o_prod(w_prod));
    nbgv_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));
    nbgv_sqrt u_sqrt (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_sreq), .o_rsp(w_srsp));

    // one read address for the whole body store
    logic [IW-1:0]      w_tgt;
    logic [IW-1:0]      w_ptr;
    logic signed [31:0] w_px, w_py, w_vx, w_vy, w_acx, w_acy;
    logic [30:0]        w_m;

    assign w_tgt = r_k[1] ? r_j : r_i;

    always_comb begin
        case (r_state)
            S_G_RDI: w_ptr = r_i;
            S_G_RDJ: w_ptr = r_j;
            S_G_PW:  w_ptr = w_tgt;
            default: w_ptr = r_b;
        endcase
    end

    assign w_px  = r_px[w_ptr];
    assign w_py  = r_py[w_ptr];
    assign w_vx  = r_vx[w_ptr];
    assign w_vy  = r_vy[w_ptr];
    assign w_m   = r_m[w_ptr];
    assign w_acx = r_acx[w_ptr];
    assign w_acy = r_acy[w_ptr];

    // pair differences, saturated
    logic signed [31:0] w_dx, w_dy;
    logic [31:0]        w_ux, w_uy;

    assign w_dx = nbgv_pkg::sat32(49'(r_pjx) - 49'(r_pix));
    assign w_dy = nbgv_pkg::sat32(49'(r_pjy) - 49'(r_piy));
    assign w_ux = nbgv_pkg::abs32(r_dx);
    assign w_uy = nbgv_pkg::abs32(r_dy);

    // pull k: bit 1 picks the body that is pulled, bit 0 the axis
    logic [63:0]        w_rat;
    logic [31:0]        w_ud;
    logic signed [31:0] w_d;
    logic               w_pneg;
    logic [95:0]        w_n96;
    logic [31:0]        w_pm;
    logic signed [48:0] w_pv;
    logic signed [31:0] w_acc_sel;
    logic signed [31:0] w_acc_new;

    assign w_rat  = r_k[1] ? r_rati : r_ratj;
    assign w_d    = r_k[0] ? r_dy : r_dx;
    assign w_ud   = r_k[0] ? w_uy : w_ux;
    // the far body pulls towards it: sign of diff, flipped for body j
    assign w_pneg = r_k[1] ? (!w_d[31] && (w_d != 32'sd0)) : w_d[31];
    assign w_n96  = {32'd0, r_p0} + {w_prod, 32'd0};
    assign w_pm   = (w_drsp.quo > 64'h8000_0000) ? 32'h8000_0000 : w_drsp.quo[31:0];
    assign w_pv   = w_pneg ? -49'(w_pm) : 49'(w_pm);
    assign w_acc_sel = r_k[0] ? w_acy : w_acx;
    assign w_acc_new = nbgv_pkg::sat32(49'(w_acc_sel) + w_pv);

    // kick and drift: v += a*dt/2, p += v*dt, truncated toward zero
    logic signed [31:0] w_ksel, w_vsel, w_psel, w_src, w_base, w_upd;
    logic signed [48:0] w_scl, w_sv;

    assign w_ksel = r_ax ? w_acy : w_acx;
    assign w_vsel = r_ax ? w_vy : w_vx;
    assign w_psel = r_ax ? w_py : w_px;
    assign w_src  = (r_state == S_K_ADD) ? w_ksel : w_vsel;
    assign w_base = (r_state == S_K_ADD) ? w_vsel : w_psel;
    assign w_scl  = (r_state == S_K_ADD) ? 49'({2'b00, w_prod[63:17]})
                                         : 49'({1'b0, w_prod[63:16]});
    assign w_sv   = w_src[31] ? -w_scl : w_scl;
    assign w_upd  = nbgv_pkg::sat32(49'(w_base) + w_sv);

    // multiplier operand selection
    always_comb begin
        case (r_state)
            S_G_M0: begin
                w_ma = w_ux;
                w_mb = w_ux;
            end
            S_G_M1: begin
                w_ma = w_uy;
                w_mb = w_uy;
            end
            S_G_M2: begin
                w_ma = {1'b0, r_soft};
                w_mb = {1'b0, r_soft};
            end
            S_G_M3: begin
                w_ma = {1'b0, r_grav};
                w_mb = {1'b0, r_mi};
            end
            S_G_M4: begin
                w_ma = {1'b0, r_grav};
                w_mb = {1'b0, r_mj};
            end
            S_G_P0: begin
                w_ma = w_rat[31:0];
                w_mb = w_ud;
            end
            S_G_P1: begin
                w_ma = w_rat[63:32];
                w_mb = w_ud;
            end
            S_K_MUL: begin
                w_ma = nbgv_pkg::abs32(w_ksel);
                w_mb = {1'b0, r_dt};
            end
            S_D_MUL: begin
                w_ma = nbgv_pkg::abs32(w_vsel);
                w_mb = {1'b0, r_dt};
            end
            default: begin
                w_ma = 32'd0;
                w_mb = 32'd0;
            end
        endcase
    end

    // divider and root requests
    logic w_wd1_go;

    assign w_wd1_go = (r_state == S_G_WD1) && w_drsp.done && w_srsp.done;

    always_comb begin
        w_dreq.go     = 1'b0;
        w_dreq.num_hi = {32'd0, w_prod[63:32]};
        w_dreq.num_lo = {w_prod[31:0], 32'd0};
        w_dreq.den    = r_den;
        case (r_state)
            S_G_M5: begin
                // ratio for pulls from body j: g*mj * 2^32 / den
                w_dreq.go = 1'b1;
            end
            S_G_WD1: begin
                w_dreq.go     = w_wd1_go;
                w_dreq.num_hi = {32'd0, r_gmi[63:32]};
                w_dreq.num_lo = {r_gmi[31:0], 32'd0};
            end
            S_G_P2: begin
                w_dreq.go     = 1'b1;
                w_dreq.num_hi = {32'd0, w_n96[95:64]};
                w_dreq.num_lo = w_n96[63:0];
                w_dreq.den    = {16'd0, r_dist, 16'd0};
            end
            default: begin
                w_dreq.go = 1'b0;
            end
        endcase
    end

    assign w_sreq.go  = (r_state == S_G_M3) && (r_sum >= nbgv_pkg::DIST_MIN_SQ);
    assign w_sreq.val = r_sum;

    // pair walk
    logic          w_last_pair;
    logic [IW-1:0] w_i1;

    assign w_last_pair = (r_i == PEN_B) && (r_j == LAST_B);
    assign w_i1        = r_i + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_grav  <= nbgv_pkg::GRAV_RESET;
            r_soft  <= 31'd0;
            r_subst <= nbgv_pkg::SUBST_RESET;
            for (int n = 0; n < NUM_BODIES; n++) begin
                r_px[n] <= 32'sd0;
                r_py[n] <= 32'sd0;
                r_vx[n] <= 32'sd0;
                r_vy[n] <= 32'sd0;
                r_m[n]  <= 31'd0;
            end
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    nbgv_pkg::CFG_GRAV:  r_grav  <= i_cfg_data;
                    nbgv_pkg::CFG_SOFT:  r_soft  <= i_cfg_data;
                    nbgv_pkg::CFG_SUBST: r_subst <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (start && !i_kind) begin
                        // load, out-of-range index is dropped
                        if (32'(i_body_index) < NUM_BODIES) begin
                            r_px[IW'(i_body_index)] <= i_in_pos_x;
                            r_py[IW'(i_body_index)] <= i_in_pos_y;
                            r_vx[IW'(i_body_index)] <= i_in_vel_x;
                            r_vy[IW'(i_body_index)] <= i_in_vel_y;
                            r_m[IW'(i_body_index)]  <= i_in_mass;
                        end
                    end else if (start) begin
                        r_dt    <= i_step_dt;
                        r_cnt   <= 7'd0;
                        r_phase <= 1'b0;
                        r_b     <= '0;
                        if (r_subst == 7'd0) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_i     <= '0;
                            r_j     <= IW'(1);
                            r_state <= S_G_RDI;
                            for (int n = 0; n < NUM_BODIES; n++) begin
                                r_acx[n] <= 32'sd0;
                                r_acy[n] <= 32'sd0;
                            end
                        end
                    end
                end
                S_G_RDI: begin
                    r_pix   <= w_px;
                    r_piy   <= w_py;
                    r_mi    <= w_m;
                    r_state <= S_G_RDJ;
                end
                S_G_RDJ: begin
                    r_pjx   <= w_px;
                    r_pjy   <= w_py;
                    r_mj    <= w_m;
                    r_state <= S_G_DIF;
                end
                S_G_DIF: begin
                    r_dx    <= w_dx;
                    r_dy    <= w_dy;
                    r_state <= S_G_M0;
                end
                S_G_M0: r_state <= S_G_M1;
                S_G_M1: begin
                    r_sum   <= w_prod;
                    r_state <= S_G_M2;
                end
                S_G_M2: begin
                    r_sum   <= r_sum + w_prod;
                    r_state <= S_G_M3;
                end
                S_G_M3: begin
                    r_den <= r_sum + w_prod;
                    if (r_sum < nbgv_pkg::DIST_MIN_SQ) begin
                        // close pair adds nothing
                        if (w_last_pair) begin
                            r_b     <= '0;
                            r_ax    <= 1'b0;
                            r_state <= S_K_MUL;
                        end else begin
                            if (r_j == LAST_B) begin
                                r_i <= w_i1;
                                r_j <= w_i1 + 1'b1;
                            end else begin
                                r_j <= r_j + 1'b1;
                            end
                            r_state <= S_G_RDI;
                        end
                    end else begin
                        r_state <= S_G_M4;
                    end
                end
                S_G_M4: begin
                    r_gmi   <= w_prod;
                    r_state <= S_G_M5;
                end
                S_G_M5: r_state <= S_G_WD1;
                S_G_WD1: begin
                    if (w_wd1_go) begin
                        r_ratj  <= w_drsp.quo;
                        r_dist  <= w_srsp.root;
                        r_state <= S_G_WD2;
                    end
                end
                S_G_WD2: begin
                    if (w_drsp.done) begin
                        r_rati  <= w_drsp.quo;
                        r_k     <= 2'd0;
                        r_state <= S_G_P0;
                    end
                end
                S_G_P0: r_state <= S_G_P1;
                S_G_P1: begin
                    r_p0    <= w_prod;
                    r_state <= S_G_P2;
                end
                S_G_P2: r_state <= S_G_PW;
                S_G_PW: begin
                    if (w_drsp.done) begin
                        if (r_k[0]) begin
                            r_acy[w_tgt] <= w_acc_new;
                        end else begin
                            r_acx[w_tgt] <= w_acc_new;
                        end
                        r_k <= r_k + 2'd1;
                        if (r_k != 2'd3) begin
                            r_state <= S_G_P0;
                        end else if (w_last_pair) begin
                            r_b     <= '0;
                            r_ax    <= 1'b0;
                            r_state <= S_K_MUL;
                        end else begin
                            if (r_j == LAST_B) begin
                                r_i <= w_i1;
                                r_j <= w_i1 + 1'b1;
                            end else begin
                                r_j <= r_j + 1'b1;
                            end
                            r_state <= S_G_RDI;
                        end
                    end
                end
                S_K_MUL: r_state <= S_K_ADD;
                S_K_ADD: begin
                    if (r_ax) begin
                        r_vy[r_b] <= w_upd;
                    end else begin
                        r_vx[r_b] <= w_upd;
                    end
                    r_ax <= !r_ax;
                    if (!r_ax) begin
                        r_state <= S_K_MUL;
                    end else if (r_b != LAST_B) begin
                        r_b     <= r_b + 1'b1;
                        r_state <= S_K_MUL;
                    end else if (!r_phase) begin
                        r_b     <= '0;
                        r_state <= S_D_MUL;
                    end else begin
                        r_phase <= 1'b0;
                        r_b     <= '0;
                        if (7'(r_cnt + 7'd1) == r_subst) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_cnt   <= r_cnt + 7'd1;
                            r_i     <= '0;
                            r_j     <= IW'(1);
                            r_state <= S_G_RDI;
                            for (int n = 0; n < NUM_BODIES; n++) begin
                                r_acx[n] <= 32'sd0;
                                r_acy[n] <= 32'sd0;
                            end
                        end
                    end
                end
                S_D_MUL: r_state <= S_D_ADD;
                S_D_ADD: begin
                    if (r_ax) begin
                        r_py[r_b] <= w_upd;
                    end else begin
                        r_px[r_b] <= w_upd;
                    end
                    r_ax <= !r_ax;
                    if (!r_ax) begin
                        r_state <= S_D_MUL;
                    end else if (r_b != LAST_B) begin
                        r_b     <= r_b + 1'b1;
                        r_state <= S_D_MUL;
                    end else begin
                        // second force pass on the drifted positions
                        r_phase <= 1'b1;
                        r_i     <= '0;
                        r_j     <= IW'(1);
                        r_state <= S_G_RDI;
                        for (int n = 0; n < NUM_BODIES; n++) begin
                            r_acx[n] <= 32'sd0;
                            r_acy[n] <= 32'sd0;
                        end
                    end
                end
                S_EMIT: begin
                    r_valid <= 1'b1;
                    r_oidx  <= 2'(r_b);
                    r_opx   <= w_px;
                    r_opy   <= w_py;
                    r_ovx   <= w_vx;
                    r_ovy   <= w_vy;
                    r_olast <= (r_b == LAST_B);
                    if (r_b == LAST_B) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_b <= r_b + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_out_index = r_oidx;
    assign o_out_pos_x = r_opx;
    assign o_out_pos_y = r_opy;
    assign o_out_vel_x = r_ovx;
    assign o_out_vel_y = r_ovy;
    assign o_last      = r_valid & r_olast;

    // results of one advance come back to back until the final body
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_valid)
        else $error("result transfer gap inside a burst");

    a_busy_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy)
        else $error("idle before the final result");

    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start) && $past(i_kind))
        else $error("busy without an advance transfer");

    a_no_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_EMIT))
        else $error("result outside the emit phase");

endmodule
`default_nettype wire

### bench/tb_nbody_gravity_verlet_step_unit.sv
// self-checking bench for the n-body velocity-verlet step unit
// depends on nbgv_pkg and nbody_gravity_verlet_step_unit, nothing else
`default_nettype none
module tb_nbody_gravity_verlet_step_unit;

    localparam int NB = 3;

    // kinds of command
    localparam bit KIND_LOAD    = 1'b0;
    localparam bit KIND_ADVANCE = 1'b1;

    typedef struct {
        bit          kind;
        logic [1:0]  idx;
        logic [31:0] px, py, vx, vy;
        logic [30:0] mass;
        logic [30:0] dt;
        bit          zero_res;  // expected results typed in: everything zero
    } t_cmd;

    typedef struct {
        logic [1:0]  index;
        logic [31:0] px, py, vx, vy;
        logic        last;
    } t_body_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_kind = 1'b0;
    logic [1:0]  i_body_index = '0;
    logic [31:0] i_in_pos_x = '0, i_in_pos_y = '0, i_in_vel_x = '0, i_in_vel_y = '0;
    logic [30:0] i_in_mass = '0, i_step_dt = '0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [30:0] i_cfg_data = '0;
    logic        o_valid, o_last;
    logic [1:0]  o_out_index;
    logic [31:0] o_out_pos_x, o_out_pos_y, o_out_vel_x, o_out_vel_y;

    nbody_gravity_verlet_step_unit #(.NUM_BODIES(NB)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .start(start), .busy(busy),
        .i_kind(i_kind), .i_body_index(i_body_index),
        .i_in_pos_x(i_in_pos_x), .i_in_pos_y(i_in_pos_y),
        .i_in_vel_x(i_in_vel_x), .i_in_vel_y(i_in_vel_y),
        .i_in_mass(i_in_mass), .i_step_dt(i_step_dt),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_out_index(o_out_index),
        .o_out_pos_x(o_out_pos_x), .o_out_pos_y(o_out_pos_y),
        .o_out_vel_x(o_out_vel_x), .o_out_vel_y(o_out_vel_y),
        .o_last(o_last)
    );

    always #6 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // predictor: own copy of bodies and registers
    // ---------------------------------------------------------------
    int          sim_px[NB], sim_py[NB], sim_vx[NB], sim_vy[NB];
    logic [30:0] sim_mass[NB];
    int          sim_ax[NB], sim_ay[NB];
    logic [30:0] sim_grav = nbgv_pkg::GRAV_RESET;
    logic [30:0] sim_soft = '0;
    logic [6:0]  sim_substeps = nbgv_pkg::SUBST_RESET;

    t_body_res   body_results_due[$];
    int          n_fail = 0, n_loads = 0, n_advances = 0, n_results = 0;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // floor(a*b/c), saturated to 64 bits
    function automatic logic [63:0] frac_quot(logic [63:0] a, logic [63:0] b, logic [63:0] c);
        logic [127:0] q;
        q = ({64'd0, a} * {64'd0, b}) / {64'd0, c};
        return (q[127:64] != 0) ? {64{1'b1}} : q[63:0];
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint pair_pull(logic [63:0] gm, logic [63:0] densq,
                                         logic [63:0] sep, longint d);
        logic [63:0] ratio, mag, ad;
        ad = (d < 0) ? 64'(-d) : 64'(d);
        ratio = frac_quot(gm, 64'd1 << 32, densq);
        mag = frac_quot(ratio, ad, sep << 16);
        if (mag > 64'h8000_0000) mag = 64'h8000_0000;
        return (d < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint dt_scale(longint a, logic [30:0] dt, int sh);
        logic [63:0] m, r;
        m = (a < 0) ? 64'(-a) : 64'(a);
        r = (m * {33'd0, dt}) >> sh;
        return (a < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic void refresh_accel();
        longint      dx, dy;
        logic [63:0] ux, uy, sq, sep, densq, gmi, gmj;
        for (int i = 0; i < NB; i++) begin
            sim_ax[i] = 0;
            sim_ay[i] = 0;
        end
        for (int i = 0; i < NB; i++) begin
            for (int j = i + 1; j < NB; j++) begin
                dx = clamp32(longint'(sim_px[j]) - sim_px[i]);
                dy = clamp32(longint'(sim_py[j]) - sim_py[i]);
                ux = (dx < 0) ? 64'(-dx) : 64'(dx);
                uy = (dy < 0) ? 64'(-dy) : 64'(dy);
                sq = ux * ux + uy * uy;
                // close pair adds nothing
                if (sq < nbgv_pkg::DIST_MIN_SQ) continue;
                sep = root_floor(sq);
                densq = sq + {33'd0, sim_soft} * {33'd0, sim_soft};
                gmi = {33'd0, sim_grav} * {33'd0, sim_mass[i]};
                gmj = {33'd0, sim_grav} * {33'd0, sim_mass[j]};
                sim_ax[i] = int'(clamp32(sim_ax[i] + pair_pull(gmj, densq, sep, dx)));
                sim_ay[i] = int'(clamp32(sim_ay[i] + pair_pull(gmj, densq, sep, dy)));
                sim_ax[j] = int'(clamp32(sim_ax[j] + pair_pull(gmi, densq, sep, -dx)));
                sim_ay[j] = int'(clamp32(sim_ay[j] + pair_pull(gmi, densq, sep, -dy)));
            end
        end
    endfunction

    function automatic void half_kick(logic [30:0] dt);
        for (int i = 0; i < NB; i++) begin
            sim_vx[i] = int'(clamp32(sim_vx[i] + dt_scale(sim_ax[i], dt, 17)));
            sim_vy[i] = int'(clamp32(sim_vy[i] + dt_scale(sim_ay[i], dt, 17)));
        end
    endfunction

    // apply one accepted command and queue the bodies it emits
    function automatic void predict_cmd(t_cmd c);
        t_body_res r;
        if (c.kind == KIND_LOAD) begin
            n_loads++;
            // an index past the last body is ignored
            if (c.idx < NB) begin
                sim_px[c.idx] = c.px;
                sim_py[c.idx] = c.py;
                sim_vx[c.idx] = c.vx;
                sim_vy[c.idx] = c.vy;
                sim_mass[c.idx] = c.mass;
            end
            return;
        end
        n_advances++;
        for (int s = 0; s < sim_substeps; s++) begin
            refresh_accel();
            half_kick(c.dt);
            for (int i = 0; i < NB; i++) begin
                sim_px[i] = int'(clamp32(sim_px[i] + dt_scale(sim_vx[i], c.dt, 16)));
                sim_py[i] = int'(clamp32(sim_py[i] + dt_scale(sim_vy[i], c.dt, 16)));
            end
            refresh_accel();
            half_kick(c.dt);
        end
        for (int i = 0; i < NB; i++) begin
            r.index = 2'(i);
            if (c.zero_res) begin
                r.px = '0; r.py = '0; r.vx = '0; r.vy = '0;
            end else begin
                r.px = sim_px[i]; r.py = sim_py[i]; r.vx = sim_vx[i]; r.vy = sim_vy[i];
            end
            r.last = (i == NB - 1);
            body_results_due.push_back(r);
        end
    endfunction

    // ---------------------------------------------------------------
    // result checker: every strobed result against the oldest one due
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_body_res e;
        if (i_rst_n && o_valid) begin
            n_results++;
            if (body_results_due.size() == 0) begin
                $error("result with nothing due: index %0d", o_out_index);
                n_fail++;
            end else begin
                e = body_results_due.pop_front();
                if (o_out_index !== e.index) begin
                    $error("out_index exp %0d got %0d", e.index, o_out_index); n_fail++;
                end
                if (o_out_pos_x !== e.px) begin
                    $error("out_pos_x exp %h got %h", e.px, o_out_pos_x); n_fail++;
                end
                if (o_out_pos_y !== e.py) begin
                    $error("out_pos_y exp %h got %h", e.py, o_out_pos_y); n_fail++;
                end
                if (o_out_vel_x !== e.vx) begin
                    $error("out_vel_x exp %h got %h", e.vx, o_out_vel_x); n_fail++;
                end
                if (o_out_vel_y !== e.vy) begin
                    $error("out_vel_y exp %h got %h", e.vy, o_out_vel_y); n_fail++;
                end
                if (o_last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, o_last); n_fail++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // command side
    // ---------------------------------------------------------------
    bit idling_on = 1'b1;

    // present one command and hold it until it is taken and busy is low again
    task automatic issue(t_cmd c);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_kind <= c.kind;
        i_body_index <= c.idx;
        i_in_pos_x <= c.px;
        i_in_pos_y <= c.py;
        i_in_vel_x <= c.vx;
        i_in_vel_y <= c.vy;
        i_in_mass <= c.mass;
        i_step_dt <= c.dt;
        do @(posedge i_clk); while (busy);
        predict_cmd(c);
    endtask

    // hold off until every due body has come and the unit has settled
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (body_results_due.size() != 0 || busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [30:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            nbgv_pkg::CFG_GRAV:  sim_grav = val;
            nbgv_pkg::CFG_SOFT:  sim_soft = val;
            nbgv_pkg::CFG_SUBST: sim_substeps = val[6:0];
            default: ;
        endcase
    endtask

    function automatic t_cmd mk_load(logic [1:0] idx, logic [31:0] px, logic [31:0] py,
                                     logic [31:0] vx, logic [31:0] vy, logic [30:0] m);
        t_cmd c;
        c = '{KIND_LOAD, idx, px, py, vx, vy, m, 31'($urandom), 1'b0};
        return c;
    endfunction

    function automatic t_cmd mk_advance(logic [30:0] dt);
        t_cmd c;
        c = '{KIND_ADVANCE, 2'($urandom), $urandom, $urandom, $urandom, $urandom,
              31'($urandom), dt, 1'b0};
        return c;
    endfunction

    // a plausible body: within about +-16.0, gentle speed, mass up to 4.0
    function automatic t_cmd mk_body(logic [1:0] idx);
        return mk_load(idx, 32'($signed($urandom_range(0, 2097152)) - 1048576),
                       32'($signed($urandom_range(0, 2097152)) - 1048576),
                       32'($signed($urandom_range(0, 131072)) - 65536),
                       32'($signed($urandom_range(0, 131072)) - 65536),
                       31'($urandom_range(0, 262144)));
    endfunction

    // wild body: every bit of every field free
    function automatic t_cmd mk_noise();
        t_cmd c;
        c = mk_advance(31'($urandom));
        c.kind = KIND_LOAD;
        return c;
    endfunction

    t_cmd directed[$];

    initial begin
        t_cmd c;
        int   n_rand;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, default registers (g 1.0, no softening, ten substeps)
        // empty system after reset: nothing moves, all bodies zero
        c = mk_advance(31'h7FFF_FFFF); c.zero_res = 1'b1; directed.push_back(c);
        directed.push_back(mk_load(2'd0, -32'sd65536, 32'd0, 32'd0, 32'sd6554, 31'd65536));
        directed.push_back(mk_load(2'd1, 32'sd65536, 32'd0, 32'd0, -32'sd6554, 31'd65536));
        directed.push_back(mk_load(2'd2, 32'd0, 32'sd131072, 32'sd3277, 32'd0, 31'd32768));
        directed.push_back(mk_advance(31'd655));
        // index past the last body: ignored
        directed.push_back(mk_load(2'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                   32'h7FFF_FFFF, 31'h7FFF_FFFF));
        directed.push_back(mk_advance(31'd655));
        // close pair: body 1 a few lsb away from body 0
        directed.push_back(mk_load(2'd0, -32'sd65536, 32'd0, 32'd0, 32'd0, 31'd65536));
        directed.push_back(mk_load(2'd1, -32'sd65536 + 32'sd20, 32'sd30, 32'd0, 32'd0,
                                   31'd65536));
        // massless body exerts no pull
        directed.push_back(mk_load(2'd2, 32'sd65536, 32'sd65536, 32'd0, 32'd0, 31'd0));
        directed.push_back(mk_advance(31'd1));
        // far bodies at the extremes, differences saturate
        directed.push_back(mk_load(2'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                   32'h7FFF_FFFF, 31'h7FFF_FFFF));
        directed.push_back(mk_load(2'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                   32'h8000_0000, 31'h7FFF_FFFF));
        directed.push_back(mk_advance(31'h7FFF_FFFF));
        directed.push_back(mk_advance(31'd0));
        directed.push_back(mk_load(2'd2, 32'd0, 32'd0, 32'd0, 32'd0, 31'h7FFF_FFFF));
        directed.push_back(mk_advance(31'd65536));
        foreach (directed[k]) issue(directed[k]);

        // zero substeps: bodies emitted unmoved
        write_reg(nbgv_pkg::CFG_SUBST, 31'd0);
        issue(mk_advance(31'd65536));
        // a run of 64 substeps, plus maximal constants
        write_reg(nbgv_pkg::CFG_SUBST, 31'd64);
        write_reg(nbgv_pkg::CFG_GRAV, 31'h7FFF_FFFF);
        write_reg(nbgv_pkg::CFG_SOFT, 31'h7FFF_FFFF);
        issue(mk_body(2'd0)); issue(mk_body(2'd1)); issue(mk_body(2'd2));
        issue(mk_advance(31'd655));
        // three substeps with zero gravity and softening, for one advance
        write_reg(nbgv_pkg::CFG_SUBST, 31'd3);
        write_reg(nbgv_pkg::CFG_GRAV, 31'd0);
        write_reg(nbgv_pkg::CFG_SOFT, 31'd0);
        issue(mk_advance(31'd6554));

        // random part: phases of fresh registers, mostly well-formed
        // reload-and-advance sequences, some noise and broken sequences
        n_rand = 0;
        while (n_rand < 78) begin
            write_reg(nbgv_pkg::CFG_GRAV,
                      ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                  : 31'($urandom_range(0, 1 << 20)));
            write_reg(nbgv_pkg::CFG_SOFT,
                      ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                  : 31'($urandom_range(0, 1 << 17)));
            write_reg(nbgv_pkg::CFG_SUBST, 31'($urandom_range(1, 3)));
            if (n_rand > 55) idling_on = 1'b0;  // last stretch runs flat out
            repeat (3) begin
                if ($urandom_range(0, 4) == 0) begin
                    // broken sequence: noise loads, bad indexes, random dt
                    repeat ($urandom_range(1, 3)) begin
                        issue(mk_noise());
                        n_rand++;
                    end
                    issue(mk_advance(31'($urandom)));
                end else begin
                    for (int b = 0; b < NB; b++) begin
                        if ($urandom_range(0, 2) != 0) issue(mk_body(2'(b)));
                        n_rand++;
                    end
                    issue(mk_advance(31'($urandom_range(0, 1 << 14))));
                end
                n_rand++;
            end
        end

        drain();
        repeat (50) @(posedge i_clk);
        $display("covered %0d loads and %0d advances, %0d body results checked",
                 n_loads, n_advances, n_results);
        if (n_fail == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #60_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire
